// ===== rtl/cde_pkg.sv =====
package cde_pkg;

	typedef enum logic [1:0] {
		CMD_WHEEL   = 2'd0,
		CMD_NEXT    = 2'd1,
		CMD_BACK    = 2'd2,
		CMD_RESTART = 2'd3
	} cde_cmd_t;

	localparam logic [1:0] FIELD_YEAR  = 2'd0;
	localparam logic [1:0] FIELD_MONTH = 2'd1;
	localparam logic [1:0] FIELD_DAY   = 2'd2;

	localparam logic [7:0]  YearSpan      = 8'd35;
	localparam logic [7:0]  MonthCount    = 8'd12;
	localparam logic [3:0]  MonthFeb      = 4'd1;
	localparam logic [15:0] BaseYearReset = 16'd2026;

	// multiplicative inverse of 25 modulo 2^16, and the largest quotient of a multiple of 25
	localparam logic [15:0] Inv25   = 16'd23593;
	localparam logic [15:0] Max25Q  = 16'd2621;

	typedef struct packed {
		cde_cmd_t           command;
		logic signed [15:0] delta;
	} cde_req_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic [1:0]  cur_field;
		logic        complete;
		logic        changed;
	} cde_rsp_t;

	// gregorian leap year; divisibility by 25 through the modular inverse
	function automatic logic is_leap(input logic [15:0] y);
		logic [15:0] p;
		logic        div25;
		p     = y * Inv25;
		div25 = (p <= Max25Q);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] mi, input logic leap);
		logic [4:0] len;
		if (mi == MonthFeb) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (mi inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

	// add delta, overshoot past either end jumps to the opposite end
	function automatic logic [7:0] step_wrap(input logic [7:0] idx,
		input logic signed [15:0] delta, input logic [7:0] span);
		logic [17:0] n;
		logic [7:0]  r;
		n = {10'd0, idx} + {{2{delta[15]}}, delta};
		if (n[17]) begin
			r = span - 8'd1;
		end else if (n[16:0] >= {9'd0, span}) begin
			r = 8'd0;
		end else begin
			r = n[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/calendar_date_editor.sv =====
// Calendar date editor: holds a year/month/day date and an active field, and applies one
// request per clock cycle unless responses stall (wheel step, next, back, restart),
// returning one response per request with the date, active field, complete flag and a
// changed flag. An accepted request passes the input register, then the result register; a new
// request may be accepted in every cycle unless responses stall, the update loop through
// the date and field registers setting that rate. The base year is written through the
// cfg channel, which is always ready; write it only while no request is in flight.
module calendar_date_editor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  cde_pkg::cde_req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output cde_pkg::cde_rsp_t  rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import cde_pkg::*;

	logic        valid_s1;
	cde_req_t    req_s1;
	logic        rsp_valid_q;
	cde_rsp_t    rsp_q;
	logic [15:0] base_year_q;
	logic [7:0]  year_idx_q;
	logic [3:0]  month_idx_q;
	logic [4:0]  day_idx_q;
	logic [1:0]  field_q;
	logic        done_q;

	logic        adv;
	logic        fire;
	logic [7:0]  year_step;
	logic [7:0]  month_step;
	logic [7:0]  day_step;
	logic [7:0]  eff_year;
	logic [3:0]  eff_month;
	logic [15:0] year_sum;
	logic [4:0]  len;
	logic        is_wheel;
	logic [7:0]  year_n;
	logic [3:0]  month_n;
	logic [4:0]  day_n;
	logic [1:0]  field_n;
	logic        done_n;
	logic        changed_n;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign fire      = valid_s1 && adv;
	assign req_ready = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year_q <= BaseYearReset;
		end else if (cfg_valid && cfg_ready) begin
			base_year_q <= cfg_data;
		end
	end

	// shared year and month-length path
	assign is_wheel   = (req_s1.command == CMD_WHEEL);
	assign year_step  = step_wrap(year_idx_q, req_s1.delta, YearSpan);
	assign month_step = step_wrap({4'd0, month_idx_q}, req_s1.delta, MonthCount);
	assign eff_year   = (is_wheel && field_q == FIELD_YEAR) ? year_step : year_idx_q;
	assign eff_month  = (is_wheel && field_q == FIELD_MONTH) ? month_step[3:0] : month_idx_q;
	assign year_sum   = base_year_q + {8'd0, eff_year};
	assign len        = month_length(eff_month, is_leap(year_sum));
	assign day_step   = step_wrap({3'd0, day_idx_q}, req_s1.delta, {3'd0, len});

	always_comb begin
		year_n    = year_idx_q;
		month_n   = month_idx_q;
		day_n     = day_idx_q;
		field_n   = field_q;
		done_n    = done_q;
		changed_n = 1'b0;
		case (req_s1.command)
			CMD_WHEEL: begin
				case (field_q)
					FIELD_YEAR: begin
						year_n = year_step;
						if (day_idx_q >= len) begin
							day_n = len - 5'd1;
						end
					end
					FIELD_MONTH: begin
						month_n = month_step[3:0];
						if (day_idx_q >= len) begin
							day_n = len - 5'd1;
						end
					end
					FIELD_DAY: begin
						day_n = day_step[4:0];
					end
					default: begin
					end
				endcase
				changed_n = (year_n != year_idx_q) || (month_n != month_idx_q)
					|| (day_n != day_idx_q);
			end
			CMD_NEXT: begin
				if (field_q == FIELD_YEAR || field_q == FIELD_MONTH) begin
					field_n = field_q + 2'd1;
				end else begin
					done_n = 1'b1;
				end
				changed_n = 1'b1;
			end
			CMD_BACK: begin
				if (field_q != FIELD_YEAR) begin
					field_n = field_q - 2'd1;
				end
				changed_n = (field_q != FIELD_YEAR);
			end
			CMD_RESTART: begin
				done_n    = 1'b0;
				changed_n = done_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_idx_q  <= '0;
			month_idx_q <= '0;
			day_idx_q   <= '0;
			field_q     <= FIELD_YEAR;
			done_q      <= 1'b0;
		end else if (fire) begin
			year_idx_q  <= year_n;
			month_idx_q <= month_n;
			day_idx_q   <= day_n;
			field_q     <= field_n;
			done_q      <= done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.day       <= day_n + 5'd1;
			rsp_q.month     <= month_n + 4'd1;
			rsp_q.year      <= year_sum;
			rsp_q.cur_field <= field_n;
			rsp_q.complete  <= done_n;
			rsp_q.changed   <= changed_n;
		end
	end

endmodule

// ===== rtl/cde_checker.sv =====
module cde_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input cde_pkg::cde_rsp_t rsp
);
	import cde_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response without a request two cycles earlier");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.month >= 4'd1 && rsp.month <= 4'd12 && rsp.day != 5'd0)
		else $error("month or day out of range");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.month != 4'd2 || rsp.day <= 5'd29)
			&& ((rsp.month != 4'd4 && rsp.month != 4'd6 && rsp.month != 4'd9
			&& rsp.month != 4'd11) || rsp.day <= 5'd30))
		else $error("day past end of month");

endmodule

bind calendar_date_editor cde_checker u_cde_checker (.*);
